// ----- hdl/psq_pkg.sv -----
// shared types, constants and table helpers for the polar node quantiser
package psq_pkg;

	localparam int LLR_WIDTH    = 16;
	localparam int QUANT_LEVELS = 8;

	// raw node result and its magnitude
	localparam int XW = LLR_WIDTH + 1;
	// table entry width and common compare width
	localparam int TW = 16;
	localparam int CW = (XW > TW + 1) ? XW : TW + 1;
	// final arithmetic width
	localparam int EW = CW + 2;

	localparam int MODE_W  = 2;
	localparam int STEP_W  = 15;
	localparam int LIMIT_W = 15;
	localparam int RW      = STEP_W;

	// remainder stages, bits of the magnitude per stage
	localparam int BPS        = 4;
	localparam int NDIV       = (XW + BPS - 1) / BPS;
	localparam int PIPE_DEPTH = NDIV + 3;

	localparam int IDX_W = 3;
	localparam int CNT_W = $clog2(QUANT_LEVELS + 1);

	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam int RIDX_W = 3;

	localparam logic [MODE_W-1:0] QM_PASS    = 2'd0;
	localparam logic [MODE_W-1:0] QM_UNIFORM = 2'd1;
	localparam logic [MODE_W-1:0] QM_TABLE   = 2'd2;

	localparam logic [RIDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [RIDX_W-1:0] REG_STEP   = 3'd1;
	localparam logic [RIDX_W-1:0] REG_LIMIT  = 3'd2;
	localparam logic [RIDX_W-1:0] REG_BND_LO = 3'd3;
	localparam logic [RIDX_W-1:0] REG_BND_HI = 3'd4;
	localparam logic [RIDX_W-1:0] REG_REC_LO = 3'd5;
	localparam logic [RIDX_W-1:0] REG_REC_HI = 3'd6;

	localparam logic ACT_F = 1'b0;
	localparam logic ACT_G = 1'b1;

	localparam logic [STEP_W-1:0]  STEP_RESET  = 15'd256;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd2048;

	typedef struct packed {
		logic                        action;
		logic signed [LLR_WIDTH-1:0] llr_a;
		logic signed [LLR_WIDTH-1:0] llr_b;
		logic                        partial_bit;
		logic                        last_in;
	} item_t;

	typedef struct packed {
		logic signed [XW-1:0] llr_out;
		logic                 last_out;
	} result_t;

	typedef struct packed {
		logic [MODE_W-1:0]  quant_mode;
		logic [STEP_W-1:0]  step_size;
		logic [LIMIT_W-1:0] clip_limit;
		logic [63:0]        boundary_low_words;
		logic [63:0]        boundary_high_words;
		logic [63:0]        recon_low_words;
		logic [63:0]        recon_high_words;
	} cfg_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic [XW-1:0]        mag;
		logic                 sat;
		logic [IDX_W-1:0]     idx;
		logic [RW-1:0]        rem;
		logic                 last;
	} pipe_t;

	// entry k of a table held in two 64-bit words, four entries per word
	function automatic logic signed [TW-1:0] table_entry(
		input logic [63:0]      lo,
		input logic [63:0]      hi,
		input logic [IDX_W-1:0] k
	);
		logic [63:0] w;
		w = k[2] ? hi : lo;
		return $signed(w[k[1:0]*TW +: TW]);
	endfunction

	// a zero step behaves as a step of one
	function automatic logic [RW-1:0] step_eff(input logic [STEP_W-1:0] s);
		return (s == '0) ? RW'(1) : s;
	endfunction

endpackage

// ----- hdl/psq_regs.sv -----
// configuration register file behind the apb port
module psq_regs
	import psq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t              cfg_q;
	logic              wr;
	logic [RIDX_W-1:0] ridx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign ridx   = paddr[ADDR_W-1:3];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quant_mode          <= QM_PASS;
			cfg_q.step_size           <= STEP_RESET;
			cfg_q.clip_limit          <= LIMIT_RESET;
			cfg_q.boundary_low_words  <= '0;
			cfg_q.boundary_high_words <= '0;
			cfg_q.recon_low_words     <= '0;
			cfg_q.recon_high_words    <= '0;
		end else if (wr) begin
			case (ridx)
				REG_MODE:   cfg_q.quant_mode          <= pwdata[MODE_W-1:0];
				REG_STEP:   cfg_q.step_size           <= pwdata[STEP_W-1:0];
				REG_LIMIT:  cfg_q.clip_limit          <= pwdata[LIMIT_W-1:0];
				REG_BND_LO: cfg_q.boundary_low_words  <= pwdata;
				REG_BND_HI: cfg_q.boundary_high_words <= pwdata;
				REG_REC_LO: cfg_q.recon_low_words     <= pwdata;
				REG_REC_HI: cfg_q.recon_high_words    <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_MODE:   prdata = DATA_W'(cfg_q.quant_mode);
			REG_STEP:   prdata = DATA_W'(cfg_q.step_size);
			REG_LIMIT:  prdata = DATA_W'(cfg_q.clip_limit);
			REG_BND_LO: prdata = cfg_q.boundary_low_words;
			REG_BND_HI: prdata = cfg_q.boundary_high_words;
			REG_REC_LO: prdata = cfg_q.recon_low_words;
			REG_REC_HI: prdata = cfg_q.recon_high_words;
			default:    prdata = '0;
		endcase
	end

endmodule

// ----- hdl/psq_node.sv -----
// first stage: f (min-sum) or g node on the two operands
module psq_node
	import psq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t item,
	output logic  out_valid,
	input  logic  out_ready,
	output pipe_t out_data
);

	logic                 valid_s1;
	pipe_t                data_s1;
	logic signed [XW-1:0] a, b, aa, ab, mn, x;
	pipe_t                nxt;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_comb begin
		a  = {item.llr_a[LLR_WIDTH-1], item.llr_a};
		b  = {item.llr_b[LLR_WIDTH-1], item.llr_b};
		aa = a[XW-1] ? -a : a;
		ab = b[XW-1] ? -b : b;
		mn = (aa < ab) ? aa : ab;
		if (item.action == ACT_G) begin
			x = (item.partial_bit ? -a : a) + b;
		end else begin
			x = (a[XW-1] ^ b[XW-1]) ? -mn : mn;
		end
		nxt      = '0;
		nxt.x    = x;
		nxt.last = item.last_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ----- hdl/psq_class.sv -----
// second stage: magnitude, clip flag and table bin of the raw result
module psq_class
	import psq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  pipe_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output pipe_t out_data
);

	logic                 valid_s2;
	pipe_t                data_s2;
	pipe_t                nxt;
	logic signed [CW-1:0] xc, bc;
	logic [CW-1:0]        mc, lc;
	logic [CNT_W-1:0]     cnt;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_comb begin
		nxt     = in_data;
		nxt.mag = $unsigned(in_data.x[XW-1] ? -in_data.x : in_data.x);
		mc      = CW'(nxt.mag);
		lc      = CW'(cfg.clip_limit);
		nxt.sat = mc > lc;
		xc      = CW'(in_data.x);
		cnt     = '0;
		// count of boundaries strictly below the result
		for (int k = 0; k < QUANT_LEVELS; k++) begin
			bc = CW'(table_entry(cfg.boundary_low_words, cfg.boundary_high_words,
				IDX_W'(k)));
			if (bc < xc) begin
				cnt = cnt + CNT_W'(1);
			end
		end
		nxt.idx = (cnt == '0) ? '0 : IDX_W'(cnt - CNT_W'(1));
		nxt.rem = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

endmodule

// ----- hdl/psq_rem_stage.sv -----
// one restoring-division stage: folds up to BPS magnitude bits into the remainder
module psq_rem_stage
	import psq_pkg::*;
#(
	parameter int FIRST = XW - 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step_size,
	input  logic              in_valid,
	output logic              in_ready,
	input  pipe_t             in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pipe_t             out_data
);

	localparam int NB = (FIRST + 1 < BPS) ? FIRST + 1 : BPS;

	logic          valid_sn;
	pipe_t         data_sn;
	pipe_t         nxt;
	logic [RW-1:0] r;
	logic [RW-1:0] rem;
	logic [RW:0]   t;

	assign in_ready  = !valid_sn || out_ready;
	assign out_valid = valid_sn;
	assign out_data  = data_sn;

	always_comb begin
		r   = step_eff(step_size);
		rem = in_data.rem;
		t   = '0;
		for (int i = 0; i < NB; i++) begin
			t = {rem, in_data.mag[FIRST-i]};
			if (t >= {1'b0, r}) begin
				t = t - {1'b0, r};
			end
			rem = t[RW-1:0];
		end
		nxt     = in_data;
		nxt.rem = rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (in_ready) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_sn <= nxt;
		end
	end

endmodule

// ----- hdl/psq_quant.sv -----
// last stage: pick pass-through, uniform or table value and hold the result
module psq_quant
	import psq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  pipe_t   in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic                 valid_so;
	result_t              data_so;
	result_t              nxt;
	logic [RW-1:0]        r, half;
	logic                 neg, adj;
	logic signed [EW-1:0] xs, re, he, se, le, sm, sres, ures, tres, y;

	assign in_ready  = !valid_so || out_ready;
	assign out_valid = valid_so;
	assign out_data  = data_so;

	always_comb begin
		r    = step_eff(cfg.step_size);
		half = r >> 1;
		neg  = in_data.x[XW-1];
		// negative value off the grid: floor moves one step further down
		adj  = neg && (in_data.rem != '0);
		xs   = EW'(in_data.x);
		re   = EW'(in_data.rem);
		he   = EW'(half);
		se   = EW'(r);
		le   = EW'(cfg.clip_limit);
		sm   = le - he;
		sres = neg ? -sm : sm;
		ures = xs + (adj ? re : -re) + (adj ? he - se : he);
		tres = EW'(table_entry(cfg.recon_low_words, cfg.recon_high_words, in_data.idx));
		case (cfg.quant_mode)
			QM_UNIFORM: y = in_data.sat ? sres : ures;
			QM_TABLE:   y = tres;
			default:    y = xs;
		endcase
		nxt.llr_out  = y[XW-1:0];
		nxt.last_out = in_data.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_so <= 1'b0;
		end else if (in_ready) begin
			valid_so <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_so <= nxt;
		end
	end

endmodule

// ----- hdl/polar_sc_node_quantized_core.sv -----
// Polar SC decoder node (f min-sum / g) with optional uniform or table quantiser on the
// result. Fully pipelined, one item per cycle when the output is not stalled, with a node
// stage, classify stage (magnitude, clip flag, table bin), NDIV remainder stages that each
// fold up to four magnitude bits into the remainder by the step size, and an output stage.
// Each stage has its own valid bit and takes a new item whenever it is empty or its
// neighbour downstream moves, so bubbles close up under output stalls.
// Configuration sits behind a 64-bit APB port at byte address 8*index; write it only
// while no item is in flight.
module polar_sc_node_quantized_core
	import psq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t        cfg;
	logic        node_valid, node_ready;
	pipe_t       node_data;
	logic [NDIV:0] dv, dr;
	pipe_t       dd [NDIV+1];

	psq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psq_node u_node (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.item      (item),
		.out_valid (node_valid),
		.out_ready (node_ready),
		.out_data  (node_data)
	);

	psq_class u_class (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (node_valid),
		.in_ready  (node_ready),
		.in_data   (node_data),
		.out_valid (dv[0]),
		.out_ready (dr[0]),
		.out_data  (dd[0])
	);

	for (genvar k = 0; k < NDIV; k++) begin : g_rem
		psq_rem_stage #(
			.FIRST (XW - 1 - k * BPS)
		) u_rem (
			.clk       (clk),
			.arst_n    (arst_n),
			.step_size (cfg.step_size),
			.in_valid  (dv[k]),
			.in_ready  (dr[k]),
			.in_data   (dd[k]),
			.out_valid (dv[k+1]),
			.out_ready (dr[k+1]),
			.out_data  (dd[k+1])
		);
	end

	psq_quant u_quant (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (dv[NDIV]),
		.in_ready  (dr[NDIV]),
		.in_data   (dd[NDIV]),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (result)
	);

endmodule

// ----- hdl/psq_check.sv -----
// port-level checker for the polar node core, bound to the top level
module psq_check
	import psq_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	localparam int OW = $clog2(PIPE_DEPTH + 1) + 1;

	logic [OW-1:0] inflight_q;
	logic          acc_in, acc_out;

	assign acc_in  = item_valid && item_ready;
	assign acc_out = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (acc_in && !acc_out) begin
			inflight_q <= inflight_q + OW'(1);
		end else if (acc_out && !acc_in) begin
			inflight_q <= inflight_q - OW'(1);
		end
	end

	// a free output lets every stage move, so the input must be open
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> item_ready)
		else $error("input stalled while output is free");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> inflight_q != '0)
		else $error("result item with no item in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= OW'(PIPE_DEPTH))
		else $error("more items in flight than pipeline stages");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result item dropped or changed");

endmodule

bind polar_sc_node_quantized_core psq_check u_psq_check (.*);
